// ===== hdl/ntds_pkg.sv =====
// shared constants, types and helpers of the nearest target dwell selector
`default_nettype none

package ntds_pkg;

  // table depth and coordinate width
  localparam int MAX_TARGETS = 16;
  localparam int COORD_BITS  = 16;

  // fixed field widths
  localparam int TGT_W    = 4;
  localparam int HOLD_W   = 8;
  localparam int TCOUNT_W = 5;
  localparam int REACH_W  = 35;

  localparam int IDX_W = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
  localparam int CNT_W = $clog2(MAX_TARGETS + 2);

  // distance arithmetic widths
  localparam int DIFF_W      = COORD_BITS + 1;
  localparam int GAP_W       = (DIFF_W > 21) ? 21 : DIFF_W;
  localparam int CLAMP_CMP_W = (DIFF_W > 21) ? DIFF_W : 21;
  localparam int SQ_W        = 2 * GAP_W;
  localparam int DIST_W      = SQ_W + 3;
  localparam int NO_WIN_W    = 24;
  localparam int BEST_W      = (DIST_W > NO_WIN_W) ? DIST_W : NO_WIN_W;
  localparam int LIM_CMP_W   = (BEST_W > REACH_W) ? BEST_W : REACH_W;

  localparam logic [CLAMP_CMP_W-1:0] GAP_CLAMP   = CLAMP_CMP_W'(1) << 20;
  localparam logic [BEST_W-1:0]      NO_WIN_DIST = BEST_W'(24'hFF_FFFF);

  // configuration port
  localparam int APB_DATA_W  = 64;
  localparam int PADDR_W     = 5;
  localparam int REG_SEL_LSB = 3;
  localparam int REG_SEL_W   = PADDR_W - REG_SEL_LSB;

  localparam logic [REG_SEL_W-1:0] REG_TARGET_COUNT = REG_SEL_W'(0);
  localparam logic [REG_SEL_W-1:0] REG_REACH_LIMIT  = REG_SEL_W'(1);
  localparam logic [REG_SEL_W-1:0] REG_HOLD_LIMIT   = REG_SEL_W'(2);

  localparam logic [TCOUNT_W-1:0] TARGET_COUNT_RST = TCOUNT_W'(0);
  localparam logic [REACH_W-1:0]  REACH_LIMIT_RST  = REACH_W'(9000);
  localparam logic [HOLD_W-1:0]   HOLD_LIMIT_RST   = HOLD_W'(10);
  localparam logic [HOLD_W-1:0]   HOLD_MAX         = '1;

  // input kind codes
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef struct packed {
    logic                         shown;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } entry_t;

  // tag that travels with an entry through the distance stages
  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
    logic             shown;
  } tag_t;

  // absolute axis gap, clamped
  function automatic logic [GAP_W-1:0] axis_gap(input logic signed [COORD_BITS-1:0] a,
                                                input logic signed [COORD_BITS-1:0] b);
    logic signed [DIFF_W-1:0] d;
    logic [DIFF_W-1:0]        m;
    logic [CLAMP_CMP_W-1:0]   w;
    d = DIFF_W'(a) - DIFF_W'(b);
    m = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    w = CLAMP_CMP_W'(m);
    if (w > GAP_CLAMP) begin
      w = GAP_CLAMP;
    end
    return GAP_W'(w);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ntds_cell.sv =====
// one ring cell holding a table entry, shifting to its neighbour during a scan
`default_nettype none

module ntds_cell
  import ntds_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   wr_en_i,
  input  wire entry_t wr_entry_i,
  input  wire logic   shift_i,
  input  wire entry_t next_i,
  output entry_t      entry_o
);

  logic                         shown_q, shown_d;
  logic signed [COORD_BITS-1:0] x_q, y_q, z_q;
  logic signed [COORD_BITS-1:0] x_d, y_d, z_d;

  always_comb begin
    shown_d = shown_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    if (wr_en_i) begin
      shown_d = wr_entry_i.shown;
      x_d     = wr_entry_i.x;
      y_d     = wr_entry_i.y;
      z_d     = wr_entry_i.z;
    end else if (shift_i) begin
      shown_d = next_i.shown;
      x_d     = next_i.x;
      y_d     = next_i.y;
      z_d     = next_i.z;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shown_q <= 1'b0;
    end else begin
      shown_q <= shown_d;
    end
  end

  // position is undefined until written
  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign entry_o = '{shown: shown_q, x: x_q, y: y_q, z: z_q};

endmodule

`default_nettype wire

// ===== hdl/ntds_dist.sv =====
// two-stage weighted squared distance unit fed from the head of the ring
`default_nettype none

module ntds_dist
  import ntds_pkg::*;
(
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire tag_t                         tag_i,
  input  wire entry_t                       entry_i,
  input  wire logic signed [COORD_BITS-1:0] ptr_x_i,
  input  wire logic signed [COORD_BITS-1:0] ptr_y_i,
  input  wire logic signed [COORD_BITS-1:0] ptr_z_i,
  output tag_t                              tag_o,
  output logic [DIST_W-1:0]                 dist_o
);

  // stage a: axis gaps
  tag_t             tag_a_q;
  logic [GAP_W-1:0] gx_q, gy_q, gz_q;
  // stage b: squares
  tag_t             tag_b_q;
  logic [SQ_W-1:0]  sx_q, sy_q, sz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_a_q <= '0;
      tag_b_q <= '0;
    end else begin
      tag_a_q <= tag_i;
      tag_b_q <= tag_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    gx_q <= axis_gap(ptr_x_i, entry_i.x);
    gy_q <= axis_gap(ptr_y_i, entry_i.y);
    gz_q <= axis_gap(ptr_z_i, entry_i.z);
    sx_q <= SQ_W'(gx_q) * SQ_W'(gx_q);
    sy_q <= SQ_W'(gy_q) * SQ_W'(gy_q);
    sz_q <= SQ_W'(gz_q) * SQ_W'(gz_q);
  end

  // z counts four times
  assign dist_o = DIST_W'(sx_q) + DIST_W'(sy_q) + (DIST_W'(sz_q) << 2);
  assign tag_o  = tag_b_q;

endmodule

`default_nettype wire

// ===== hdl/nearest_target_dwell_select_top.sv =====
// top level: target ring, distance unit, nearest search, dwell tracking, register port
//
//  channel   direction  handshake                   word
//  in        sink       in_valid_i / in_stall_o     kind, index, x, y, z, visible
//  out       source     out_valid_o / out_stall_i   hit, nearest, selection, count, fire
//  config    apb slave  psel/penable/pwrite/pready  target_count, reach_limit, hold_limit
//
// a table write gives no output word
// a pointer sample is taken, every entry of the target ring is rotated past the distance unit,
// the stages of the distance unit drain, and the dwell state is updated into the output register
// in_stall_o is high from the cycle after a sample is taken until its update is done; the
// update waits while a previous output word is still stalled
// reset clears the visible flags, selection and dwell count and sets the registers to their
// reset values; positions stay undefined until written; no clearing pass is needed
`default_nettype none

module nearest_target_dwell_select_top
  import ntds_pkg::*;
(
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // input words
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         kind_i,
  input  wire logic [TGT_W-1:0]             target_index_i,
  input  wire logic signed [COORD_BITS-1:0] coord_x_i,
  input  wire logic signed [COORD_BITS-1:0] coord_y_i,
  input  wire logic signed [COORD_BITS-1:0] coord_z_i,
  input  wire logic                         entry_visible_i,
  // output words
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              hit_o,
  output logic [TGT_W-1:0]                  nearest_target_o,
  output logic                              selected_valid_o,
  output logic [TGT_W-1:0]                  selected_target_o,
  output logic [HOLD_W-1:0]                 hold_count_o,
  output logic                              fire_o,
  // register port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [PADDR_W-1:0]           paddr,
  input  wire logic [APB_DATA_W-1:0]        pwdata,
  output logic [APB_DATA_W-1:0]             prdata,
  output logic                              pready
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  localparam logic [CNT_W-1:0] CNT_FEED_END = CNT_W'(MAX_TARGETS);
  localparam logic [CNT_W-1:0] CNT_LAST     = CNT_W'(MAX_TARGETS + 1);

  // ---------------------------------------------------------------- registers
  logic [TCOUNT_W-1:0] tcount_q;
  logic [REACH_W-1:0]  reach_q;
  logic [HOLD_W-1:0]   hold_lim_q;
  logic                cfg_wr;
  logic [REG_SEL_W-1:0] reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[PADDR_W-1:REG_SEL_LSB];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tcount_q   <= TARGET_COUNT_RST;
      reach_q    <= REACH_LIMIT_RST;
      hold_lim_q <= HOLD_LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_TARGET_COUNT: tcount_q   <= pwdata[TCOUNT_W-1:0];
        REG_REACH_LIMIT:  reach_q    <= pwdata[REACH_W-1:0];
        REG_HOLD_LIMIT:   hold_lim_q <= pwdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_TARGET_COUNT: prdata = APB_DATA_W'(tcount_q);
      REG_REACH_LIMIT:  prdata = APB_DATA_W'(reach_q);
      REG_HOLD_LIMIT:   prdata = APB_DATA_W'(hold_lim_q);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- control
  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             in_acc;
  logic             sample_acc;
  logic             write_acc;
  logic             feeding;
  logic             out_free;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign sample_acc = in_acc && (kind_i == KIND_SAMPLE);
  assign write_acc  = in_acc && (kind_i == KIND_WRITE);
  assign feeding    = (state_q == ST_SCAN) && (cnt_q < CNT_FEED_END);
  assign out_free   = !out_valid_o || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (sample_acc) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // pointer of the sample under way
  logic signed [COORD_BITS-1:0] ptr_x_q, ptr_y_q, ptr_z_q;

  always_ff @(posedge clk_i) begin
    if (sample_acc) begin
      ptr_x_q <= coord_x_i;
      ptr_y_q <= coord_y_i;
      ptr_z_q <= coord_z_i;
    end
  end

  // ---------------------------------------------------------------- target ring
  // each cell passes its entry down one place per scan cycle while the ring is fed; after MAX_TARGETS
  // shifts every entry is back home, with entry k at the head when the scan count is k
  entry_t ring[MAX_TARGETS];
  entry_t wr_entry;

  assign wr_entry = '{shown: entry_visible_i, x: coord_x_i, y: coord_y_i, z: coord_z_i};

  for (genvar i = 0; i < MAX_TARGETS; i++) begin : g_cell
    ntds_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .wr_en_i    (write_acc && (32'(target_index_i) == 32'(i))),
      .wr_entry_i (wr_entry),
      .shift_i    (feeding),
      .next_i     (ring[(i + 1) % MAX_TARGETS]),
      .entry_o    (ring[i])
    );
  end

  // ---------------------------------------------------------------- distance unit
  tag_t              head_tag;
  tag_t              dist_tag;
  logic [DIST_W-1:0] dist_val;

  // only the first target_count entries take part
  assign head_tag = '{vld:   feeding && (32'(cnt_q) < 32'(tcount_q)),
                      idx:   cnt_q[IDX_W-1:0],
                      shown: ring[0].shown};

  ntds_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tag_i   (head_tag),
    .entry_i (ring[0]),
    .ptr_x_i (ptr_x_q),
    .ptr_y_i (ptr_y_q),
    .ptr_z_i (ptr_z_q),
    .tag_o   (dist_tag),
    .dist_o  (dist_val)
  );

  // ---------------------------------------------------------------- nearest search
  // strict less-than keeps the first of equal distances; the start value never wins
  logic [BEST_W-1:0] best_dist_q;
  logic [IDX_W-1:0]  best_idx_q;
  logic              best_shown_q;
  logic              found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (sample_acc) begin
      found_q <= 1'b0;
    end else if (dist_tag.vld && (BEST_W'(dist_val) < best_dist_q)) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_acc) begin
      best_dist_q  <= NO_WIN_DIST;
      best_idx_q   <= '0;
      best_shown_q <= 1'b0;
    end else if (dist_tag.vld && (BEST_W'(dist_val) < best_dist_q)) begin
      best_dist_q  <= BEST_W'(dist_val);
      best_idx_q   <= dist_tag.idx;
      best_shown_q <= dist_tag.shown;
    end
  end

  // ---------------------------------------------------------------- dwell tracking
  logic              sel_valid_q, sel_valid_d;
  logic [IDX_W-1:0]  sel_idx_q, sel_idx_d;
  logic [HOLD_W-1:0] dwell_q, dwell_d;
  logic              hit;
  logic              fire;
  logic              sel_live;
  logic [HOLD_W-1:0] dwell_up;
  logic              do_update;

  assign do_update = (state_q == ST_UPDATE) && out_free;
  assign hit       = found_q && best_shown_q
                     && (LIM_CMP_W'(best_dist_q) <= LIM_CMP_W'(reach_q));
  // a count already at zero drops the selection before this sample
  assign sel_live  = sel_valid_q && (dwell_q != '0);
  assign dwell_up  = (dwell_q == HOLD_MAX) ? HOLD_MAX : dwell_q + HOLD_W'(1);

  always_comb begin
    sel_valid_d = sel_live;
    sel_idx_d   = sel_idx_q;
    dwell_d     = dwell_q;
    fire        = 1'b0;
    if (hit) begin
      if (!sel_live || (sel_idx_q != best_idx_q)) begin
        // new target: restart the dwell
        sel_valid_d = 1'b1;
        sel_idx_d   = best_idx_q;
        dwell_d     = HOLD_W'(1);
      end else if (dwell_up >= hold_lim_q) begin
        fire        = 1'b1;
        sel_valid_d = 1'b0;
        dwell_d     = '0;
      end else begin
        dwell_d = dwell_up;
      end
    end else if (sel_live) begin
      dwell_d = dwell_q - HOLD_W'(1);
      if (dwell_d == '0) begin
        sel_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_valid_q <= 1'b0;
      sel_idx_q   <= '0;
      dwell_q     <= '0;
    end else if (do_update) begin
      sel_valid_q <= sel_valid_d;
      sel_idx_q   <= sel_idx_d;
      dwell_q     <= dwell_d;
    end
  end

  // ---------------------------------------------------------------- output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (do_update) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_update) begin
      hit_o             <= hit;
      nearest_target_o  <= found_q ? TGT_W'(best_idx_q) : '0;
      selected_valid_o  <= sel_valid_d;
      selected_target_o <= sel_valid_d ? TGT_W'(sel_idx_d) : '0;
      hold_count_o      <= dwell_d;
      fire_o            <= fire;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire
